// File: src/rgd_pkg.sv
package rgd_pkg;

	// fixed field widths
	localparam int ChanW  = 3;
	localparam int OffW   = 5;
	localparam int RandW  = 32;
	localparam int PulseW = 16;
	localparam int ModeW  = 2;
	localparam int GateW  = 8;
	localparam int SpanW  = ChanW + 1;

	// defaults for the top level parameters
	localparam int DefPulseTicks = 48;
	localparam int DefChannels   = 8;

	// mode codes
	localparam logic [ModeW-1:0] ModeTrigger = 2'd0;
	localparam logic [ModeW-1:0] ModeHold    = 2'd1;
	localparam logic [ModeW-1:0] ModeGate    = 2'd2;

	// register indexes of the config channel
	localparam logic [1:0] RegLowKnob  = 2'd0;
	localparam logic [1:0] RegHighKnob = 2'd1;

	// start request for the remainder unit
	typedef struct packed {
		logic             start;
		logic [RandW-1:0] dividend;
		logic [SpanW-1:0] divisor;
	} div_req_t;

	// knob plus offset, saturated to 0..top
	function automatic logic [ChanW-1:0] clamp_chan(
		input logic [ChanW-1:0]       knob,
		input logic signed [OffW-1:0] off,
		input logic [ChanW-1:0]       top
	);
		logic signed [OffW:0] sum;
		logic signed [OffW:0] lim;
		sum = $signed({3'b000, knob}) + $signed({off[OffW-1], off});
		lim = $signed({3'b000, top});
		if (sum > lim) begin
			return top;
		end else if (sum < 0) begin
			return '0;
		end
		return sum[ChanW-1:0];
	endfunction

endpackage

// File: src/rgd_divider.sv
module rgd_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  rgd_pkg::div_req_t req,
	output logic              done,
	output logic [rgd_pkg::ChanW-1:0] rem
);
	import rgd_pkg::*;

	localparam int CntW = $clog2(RandW);

	logic [RandW-1:0] dividend_q;
	logic [SpanW-1:0] divisor_q;
	logic [ChanW-1:0] rem_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [SpanW-1:0] trial;
	logic [ChanW-1:0] rem_next;

	// restoring remainder, one dividend bit per cycle, msb first
	always_comb begin
		trial = {rem_q, dividend_q[RandW-1]};
		if (trial >= divisor_q) begin
			rem_next = ChanW'(trial - divisor_q);
		end else begin
			rem_next = trial[ChanW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(RandW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dividend_q <= req.dividend;
			divisor_q  <= req.divisor;
			rem_q      <= '0;
		end else if (busy_q) begin
			dividend_q <= {dividend_q[RandW-2:0], 1'b0};
			rem_q      <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: src/rgd_pulse_bank.sv
module rgd_pulse_bank #(
	parameter int PULSE_TICKS = rgd_pkg::DefPulseTicks,
	parameter int CHANNELS    = rgd_pkg::DefChannels
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      update,
	input  logic [rgd_pkg::GateW-1:0] active_in,
	output logic [rgd_pkg::GateW-1:0] active_out,
	output logic [rgd_pkg::GateW-1:0] gates
);
	import rgd_pkg::*;

	localparam logic [PulseW-1:0] PulseLoad = PulseW'(PULSE_TICKS);

	for (genvar i = 0; i < GateW; i++) begin : g_lane
		if (i < CHANNELS) begin : g_used
			logic              prev_q;
			logic [PulseW-1:0] cnt_q;
			logic              rise;
			logic [PulseW-1:0] load;

			// a new activation reloads the counter and consumes the active bit
			assign rise          = active_in[i] & ~prev_q;
			assign load          = rise ? PulseLoad : cnt_q;
			assign gates[i]      = (load != '0);
			assign active_out[i] = active_in[i] & ~rise;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					prev_q <= 1'b0;
					cnt_q  <= '0;
				end else if (update) begin
					prev_q <= active_in[i];
					cnt_q  <= (load != '0) ? load - 1'b1 : load;
				end
			end
		end else begin : g_unused
			assign gates[i]      = 1'b0;
			assign active_out[i] = 1'b0;
		end
	end

endmodule

// File: src/random_gate_distributor_unit.sv
// Random gate distributor: each input item is one sample tick and yields exactly one result
// item holding the eight gate outputs and the mode after the tick. The channel window runs
// from low knob plus low offset to high knob plus high offset, both saturated to
// 0..CHANNELS-1, with the low end pulled down to the high end when it lies above it. On a
// rising edge of clock_level one channel in the window is chosen as low plus random_word
// modulo (span + 1) and becomes the only active channel. A rising edge of mode_button steps
// trigger, hold, gate, trigger, before the clock edge is looked at. Trigger mode gives a
// PULSE_TICKS tick pulse per new activation, hold gives the active channel, gate gives it
// only while clock_level is high. A tick's result is written to the output register in
// StFin once that register is free or being emptied, and the next tick can be taken after
// that; a tick with a clock edge and a window wider than one channel first waits in StDiv
// while the remainder unit retires one bit of the 32-bit random word per cycle. The input
// side takes one item at a time; the result waits in an output register, so the next tick
// can be accepted while it is not yet taken. Knobs are to be written on the cfg channel
// only between ticks by the user; the block does not enforce it, cfg_ready is always high.
module random_gate_distributor_unit #(
	parameter int PULSE_TICKS = rgd_pkg::DefPulseTicks,
	parameter int CHANNELS    = rgd_pkg::DefChannels
) (
	input  logic        clk,
	input  logic        arst_n,
	// input tick
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // clock_level, mode_button, low_cv_offset[4:0],
	                               // high_cv_offset[4:0], random_word[31:0], zero fill
	// result
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // gate_bits[7:0], current_mode[1:0], zero fill
	// knob writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data
);
	import rgd_pkg::*;

	localparam logic [ChanW-1:0] TopChan = ChanW'(CHANNELS - 1);
	localparam logic [GateW-1:0] ChanMask = GateW'((1 << CHANNELS) - 1);

	// sequencer states
	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StDiv  = 2'd1;
	localparam logic [1:0] StFin  = 2'd2;

	logic [1:0]       state_q;
	logic [ChanW-1:0] low_knob_q;
	logic [ChanW-1:0] high_knob_q;
	logic [ModeW-1:0] mode_q;
	logic             clk_prev_q;
	logic             btn_prev_q;
	logic [GateW-1:0] active_q;

	// tick held while it is worked on
	logic             clk_lvl_q;
	logic             rise_q;
	logic [ChanW-1:0] lo_q;
	logic [ChanW-1:0] hi_q;

	logic             m_tvalid_q;
	logic [15:0]      m_tdata_q;

	// field decode
	logic                   in_clk;
	logic                   in_btn;
	logic signed [OffW-1:0] in_low_off;
	logic signed [OffW-1:0] in_high_off;
	logic [RandW-1:0]       in_rnd;

	logic             accept;
	logic [ChanW-1:0] lo_raw;
	logic [ChanW-1:0] hi_c;
	logic [ChanW-1:0] lo_c;
	logic             clk_rise;
	logic             need_div;

	div_req_t         div_req;
	logic             div_done;
	logic [ChanW-1:0] div_rem;

	logic             fin_fire;
	logic [ChanW-1:0] span;
	logic [ChanW-1:0] pick;
	logic [GateW-1:0] new_active;
	logic             bank_update;
	logic [GateW-1:0] bank_active;
	logic [GateW-1:0] bank_gates;
	logic [GateW-1:0] gates;

	assign in_clk      = s_tdata[0];
	assign in_btn      = s_tdata[1];
	assign in_low_off  = s_tdata[6:2];
	assign in_high_off = s_tdata[11:7];
	assign in_rnd      = s_tdata[43:12];

	assign s_tready  = (state_q == StIdle);
	assign accept    = s_tvalid & s_tready;
	assign cfg_ready = 1'b1;

	// channel window
	assign lo_raw   = clamp_chan(low_knob_q, in_low_off, TopChan);
	assign hi_c     = clamp_chan(high_knob_q, in_high_off, TopChan);
	assign lo_c     = (lo_raw > hi_c) ? hi_c : lo_raw;
	assign clk_rise = in_clk & ~clk_prev_q;
	assign need_div = clk_rise & (hi_c != lo_c);

	// remainder unit only runs on a clock edge when the window has more than one channel
	assign div_req.start    = accept & need_div;
	assign div_req.dividend = in_rnd;
	assign div_req.divisor  = SpanW'(hi_c - lo_c) + 1'b1;

	rgd_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.rem    (div_rem)
	);

	// result is written once the output register is free or being emptied
	assign fin_fire = (state_q == StFin) & (~m_tvalid_q | m_tready);

	assign span = hi_q - lo_q;
	assign pick = (span == '0) ? hi_q : ChanW'(lo_q + div_rem);

	always_comb begin
		if (rise_q) begin
			new_active = (GateW'(1) << pick) & ChanMask;
		end else begin
			new_active = active_q;
		end
	end

	assign bank_update = fin_fire & (mode_q == ModeTrigger);

	rgd_pulse_bank #(
		.PULSE_TICKS (PULSE_TICKS),
		.CHANNELS    (CHANNELS)
	) u_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.update     (bank_update),
		.active_in  (new_active),
		.active_out (bank_active),
		.gates      (bank_gates)
	);

	always_comb begin
		unique case (mode_q)
			ModeTrigger: gates = bank_gates;
			ModeHold:    gates = new_active;
			ModeGate:    gates = clk_lvl_q ? new_active : '0;
			default:     gates = '0;
		endcase
	end

	// knob registers, out of range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_knob_q  <= '0;
			high_knob_q <= 3'd7;
		end else if (cfg_valid & cfg_ready) begin
			if (cfg_index == RegLowKnob) begin
				low_knob_q <= cfg_data;
			end else if (cfg_index == RegHighKnob) begin
				high_knob_q <= cfg_data;
			end
		end
	end

	// sequencer and tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= StIdle;
			mode_q     <= ModeTrigger;
			clk_prev_q <= 1'b0;
			btn_prev_q <= 1'b0;
			active_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// a new result replaces the one being taken
			if (fin_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				StIdle: begin
					if (accept) begin
						// mode step comes before the clock edge
						if (in_btn & ~btn_prev_q) begin
							mode_q <= (mode_q == ModeGate) ? ModeTrigger : mode_q + 1'b1;
						end
						btn_prev_q <= in_btn;
						clk_prev_q <= in_clk;
						state_q    <= need_div ? StDiv : StFin;
					end
				end
				StDiv: begin
					if (div_done) begin
						state_q <= StFin;
					end
				end
				StFin: begin
					if (fin_fire) begin
						active_q <= (mode_q == ModeTrigger) ? bank_active : new_active;
						state_q  <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			clk_lvl_q <= in_clk;
			rise_q    <= clk_rise;
			lo_q      <= lo_c;
			hi_q      <= hi_c;
		end
		if (fin_fire) begin
			m_tdata_q <= {6'b000000, mode_q, gates};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTH
	// at most one channel is ever latched active
	a_active_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(active_q))
		else $error("more than one active channel");

	// hold and gate modes show at most one gate
	a_gate_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[9:8] != ModeTrigger) |-> $onehot0(m_tdata[7:0]))
		else $error("several gates high outside trigger mode");

	// the chosen offset stays inside the window
	a_rem_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StFin && rise_q && span != '0) |-> (div_rem <= span))
		else $error("remainder beyond the window span");
`endif

endmodule
